### rtl/mpq_pkg.sv
// package for the max priority queue
// queue depth, operation and status codes, controller types; no dependencies
package mpq_pkg;

  localparam int DEPTH = 8;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } sts_t;

endpackage

### rtl/mpq_if.sv
// valid/ready channel interfaces for the queue request and result words
// no dependencies
interface mpq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] item_value;
  logic [15:0]        item_priority;

  modport source(output valid, output func, output item_value, output item_priority,
                 input ready);
  modport sink(input valid, input func, input item_value, input item_priority,
               output ready);
endinterface

interface mpq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic [15:0]        out_priority;
  logic [1:0]         status;
  logic [3:0]         fill_count;

  modport source(output valid, output out_value, output out_priority, output status,
                 output fill_count, input ready);
  modport sink(input valid, input out_value, input out_priority, input status,
               input fill_count, output ready);
endinterface

### rtl/mpq_ctrl.sv
// controller state machine of the max priority queue
// uses mpq_pkg; drives datapath commands and the handshake signals
module mpq_ctrl import mpq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.need_scan ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.finish | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/mpq_datapath.sv
// datapath of the max priority queue: entry registers, priority scan, result register
// uses mpq_pkg; sequenced by mpq_ctrl
module mpq_datapath import mpq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_item_value,
  input  logic [15:0]        in_item_priority,
  output logic signed [31:0] out_value,
  output logic [15:0]        out_priority,
  output logic [1:0]         out_status,
  output logic [3:0]         out_fill_count
);

  logic signed [31:0] val_r [DEPTH];
  logic [15:0]        pri_r [DEPTH];
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic [1:0]         op_r;
  logic signed [31:0] new_val_r;
  logic [15:0]        new_pri_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic signed [31:0] best_val_r;
  logic [15:0]        best_pri_r;

  logic signed [31:0] res_val, out_value_r;
  logic [15:0]        res_pri, out_priority_r;
  logic [1:0]         res_sts, out_status_r;
  logic [3:0]         out_fill_r;
  logic               do_store, do_shift;

  assign sts.need_scan = (in_func == OP_POP || in_func == OP_PEEK) && (count_r > CNT_W'(1));
  assign sts.scan_last = (CNT_W'(idx_r) == count_r - CNT_W'(1));

  always_comb begin
    res_val   = '0;
    res_pri   = '0;
    res_sts   = STS_OK;
    count_nxt = count_r;
    do_store  = 1'b0;
    do_shift  = 1'b0;
    unique case (op_r)
      OP_PUSH: begin
        if (count_r == CNT_W'(DEPTH)) begin
          res_sts = STS_FULL;
        end else begin
          do_store  = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (count_r == '0) begin
          res_sts = STS_EMPTY;
        end else begin
          res_val = best_val_r;
          res_pri = best_pri_r;
          if (op_r == OP_POP) begin
            do_shift  = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // request latch and oldest-first priority scan, one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_func;
      new_val_r  <= in_item_value;
      new_pri_r  <= in_item_priority;
      idx_r      <= IDX_W'(1);
      best_idx_r <= '0;
      best_val_r <= val_r[0];
      best_pri_r <= pri_r[0];
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + IDX_W'(1);
      // strict compare keeps the oldest entry on a tie
      if (pri_r[idx_r] > best_pri_r) begin
        best_idx_r <= idx_r;
        best_val_r <= val_r[idx_r];
        best_pri_r <= pri_r[idx_r];
      end
    end
  end

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_entry
      always_ff @(posedge clk) begin
        if (cmd.finish) begin
          if (do_store && count_r == CNT_W'(k)) begin
            val_r[k] <= new_val_r;
            pri_r[k] <= new_pri_r;
          end
          if (k < DEPTH - 1) begin
            // entries above the removed one move down by one place
            if (do_shift && IDX_W'(k) >= best_idx_r) begin
              val_r[k] <= val_r[(k < DEPTH - 1) ? k + 1 : k];
              pri_r[k] <= pri_r[(k < DEPTH - 1) ? k + 1 : k];
            end
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.finish) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_r    <= res_val;
      out_priority_r <= res_pri;
      out_status_r   <= res_sts;
      out_fill_r     <= 4'(count_nxt);
    end
  end

  assign out_value      = out_value_r;
  assign out_priority   = out_priority_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

endmodule

### rtl/max_priority_queue.sv
// Bounded max-priority queue of DEPTH entries (mpq_pkg) kept in arrival order. Each
// request word gives one result word. A push, a no-op code, or any request on a queue
// holding at most one entry skips the priority scan; a pop or peek on more entries
// runs the priority scan, which reads one entry register per cycle. The result
// sits in an output register, so the next request is taken as soon as the previous
// result is loaded, even if it has not been taken yet. Ties go to the oldest entry.
// uses mpq_pkg, mpq_if, mpq_ctrl, mpq_datapath
module max_priority_queue import mpq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mpq_in_if.sink     in_ch,
  mpq_out_if.source  out_ch
);

  cmd_t cmd;
  sts_t sts;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpq_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_ch.func),
    .in_item_value    (in_ch.item_value),
    .in_item_priority (in_ch.item_priority),
    .out_value        (out_ch.out_value),
    .out_priority     (out_ch.out_priority),
    .out_status       (out_ch.status),
    .out_fill_count   (out_ch.fill_count)
  );

endmodule

### rtl/mpq_checker.sv
// port-level checks for the max priority queue, bound to the top level
// uses mpq_pkg
module mpq_checker import mpq_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_value,
  input logic [15:0]        out_priority,
  input logic [1:0]         out_status,
  input logic [3:0]         out_fill_count
);

  // reset leaves no result word pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_priority)
      && $stable(out_status) && $stable(out_fill_count))
    else $error("stalled result word changed");

  // an empty report carries no entry and an empty fill count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_EMPTY |->
      out_value == '0 && out_priority == '0 && out_fill_count == '0)
    else $error("empty result not zero");

  // a dropped push only happens with every entry in use
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_FULL |->
      out_fill_count == 4'(DEPTH) && out_value == '0 && out_priority == '0)
    else $error("full status with free entries");

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_value      (out_ch.out_value),
  .out_priority   (out_ch.out_priority),
  .out_status     (out_ch.status),
  .out_fill_count (out_ch.fill_count)
);

### test/tb_top.sv
// testbench for max_priority_queue: request words go in through a bursty driver, results
// are checked against a cycle-free queue predictor in arrival order, with a stalling sink
// uses mpq_pkg and the mpq_in_if / mpq_out_if channel interfaces
module tb_top import mpq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // code 3 is unused by the block and acts as a no-op
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int RANDOM_OPS  = 800;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 2 * DEPTH + 4;

  typedef struct {
    logic [1:0]         func;
    logic signed [31:0] value;
    logic [15:0]        prio;
    bit                 drain_first;
  } queue_op_t;

  typedef struct {
    logic signed [31:0] value;
    logic [15:0]        prio;
    logic [1:0]         status;
    logic [3:0]         fill;
  } queue_reply_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_HOLD} sink_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  mpq_in_if  in_ch();
  mpq_out_if out_ch();

  max_priority_queue u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  queue_op_t    queued_ops[$];
  queue_reply_t awaited_replies[$];

  // shadow copy of the queue contents, kept in arrival order
  logic signed [31:0] held_value[DEPTH];
  logic [15:0]        held_prio[DEPTH];
  int                 held_count = 0;

  int fail_count = 0;
  int cycle_count = 0;
  logic in_fired = 1'b0;

  function automatic queue_reply_t serve_request(queue_op_t op);
    queue_reply_t r;
    int top;
    r.value  = '0;
    r.prio   = '0;
    r.status = STS_OK;
    case (op.func)
      OP_PUSH: begin
        if (held_count >= DEPTH) begin
          r.status = STS_FULL;
        end else begin
          held_value[held_count] = op.value;
          held_prio[held_count]  = op.prio;
          held_count++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (held_count == 0) begin
          r.status = STS_EMPTY;
        end else begin
          // strict compare keeps the oldest entry on a tie
          top = 0;
          for (int k = 1; k < held_count; k++)
            if (held_prio[k] > held_prio[top]) top = k;
          r.value = held_value[top];
          r.prio  = held_prio[top];
          if (op.func == OP_POP) begin
            for (int k = top; k + 1 < held_count; k++) begin
              held_value[k] = held_value[k + 1];
              held_prio[k]  = held_prio[k + 1];
            end
            held_count--;
          end
        end
      end
      default: ;
    endcase
    r.fill = 4'(held_count);
    return r;
  endfunction

  task automatic add_op(input logic [1:0] f, input logic signed [31:0] v,
                        input logic [15:0] p, input bit drain);
    queue_op_t op;
    op.func        = f;
    op.value       = v;
    op.prio        = p;
    op.drain_first = drain;
    queued_ops.push_back(op);
  endtask

  // result check first, then prediction for the word taken at this edge
  always @(posedge clk) begin
    queue_reply_t want;
    queue_op_t    got_op;
    cycle_count <= cycle_count + 1;
    in_fired    <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_replies.size() == 0) begin
        $error("result word with nothing expected: value %0d priority %0d status %0d fill %0d",
               out_ch.out_value, out_ch.out_priority, out_ch.status, out_ch.fill_count);
        fail_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_ch.out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_ch.out_value);
          fail_count++;
        end
        if (out_ch.out_priority !== want.prio) begin
          $error("out_priority: expected %0d, got %0d", want.prio, out_ch.out_priority);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.fill_count !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, out_ch.fill_count);
          fail_count++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      got_op.func        = in_ch.func;
      got_op.value       = in_ch.item_value;
      got_op.prio        = in_ch.item_priority;
      got_op.drain_first = 1'b0;
      awaited_replies.push_back(serve_request(got_op));
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // request driver: bursts of words with random gaps between them
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (queued_ops.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (queued_ops[0].drain_first && awaited_replies.size() != 0) begin
        // hold off until every outstanding result is back
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid         <= 1'b1;
        in_ch.func          <= queued_ops[0].func;
        in_ch.item_value    <= queued_ops[0].value;
        in_ch.item_priority <= queued_ops[0].prio;
        void'(queued_ops.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // result sink: the stall pattern is drawn anew at random whenever sink_tick wraps
  sink_mode_t sink_mode = SINK_OPEN;
  int sink_tick = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_OPEN:   out_ch.ready <= 1'b1;
        SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: out_ch.ready <= (sink_tick % 4 == 0);
        default:     out_ch.ready <= (sink_tick >= 12);
      endcase
      if (sink_tick == 49) begin
        sink_tick <= 0;
        sink_mode <= sink_mode_t'($urandom_range(0, 3));
      end else begin
        sink_tick <= sink_tick + 1;
      end
    end
  end

  initial begin
    mix_t mix;
    int push_pct;
    int roll;
    int prio_roll;
    logic [1:0] f;
    logic [15:0] p;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = OP_PUSH;
    in_ch.item_value    = '0;
    in_ch.item_priority = '0;
    out_ch.ready        = 1'b0;

    // empty queue corners, then value and priority extremes with a tie on top
    add_op(OP_PEEK, 32'sd0, 16'd0, 1'b0);
    add_op(OP_POP, 32'sd0, 16'd0, 1'b0);
    add_op(OP_NOP, 32'sd0, 16'd0, 1'b0);
    add_op(OP_PUSH, 32'sh8000_0000, 16'h0000, 1'b0);
    add_op(OP_PUSH, 32'sh7fff_ffff, 16'hffff, 1'b0);
    add_op(OP_PUSH, -32'sd1, 16'hffff, 1'b0);
    add_op(OP_PEEK, 32'sd0, 16'd0, 1'b0);
    for (int k = 3; k < DEPTH; k++)
      add_op(OP_PUSH, $urandom(), 16'($urandom_range(0, 65535)), 1'b0);
    // full queue drops the push
    add_op(OP_PUSH, 32'sd12345, 16'hffff, 1'b0);
    add_op(OP_NOP, $urandom(), 16'($urandom()), 1'b0);
    for (int k = 0; k <= DEPTH; k++)
      add_op(OP_POP, $urandom(), 16'($urandom()), 1'b0);

    mix = MIX_EVEN;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) mix = mix_t'($urandom_range(0, 2));
      case (mix)
        MIX_FILL:  push_pct = 65;
        MIX_DRAIN: push_pct = 25;
        default:   push_pct = 45;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct) f = OP_PUSH;
      else if (roll < push_pct + (100 - push_pct) * 6 / 10) f = OP_POP;
      else if (roll < 95) f = OP_PEEK;
      else f = OP_NOP;
      // narrow priorities give plenty of ties
      prio_roll = $urandom_range(0, 99);
      if (prio_roll < 50) p = 16'($urandom_range(0, 65535));
      else if (prio_roll < 80) p = 16'($urandom_range(0, 3));
      else p = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      add_op(f, $urandom(), p, n % 150 == 0);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (queued_ops.size() != 0 || in_ch.valid || awaited_replies.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
